// ===== design/izp_pkg.sv =====
// ----------------------------------------------------------------------------
// izp_pkg
// Shared widths, register indexes and request codes for the zero-padded
// image convolution core.
// ----------------------------------------------------------------------------
package izp_pkg;

  // default frame store geometry
  localparam int DEF_MAX_WIDTH    = 64;
  localparam int DEF_MAX_HEIGHT   = 64;
  localparam int DEF_MAX_CHANNELS = 4;

  // kernel geometry, fixed by the coefficient register layout
  localparam int MAX_KERNEL = 3;
  localparam int KCNT_W     = $clog2(MAX_KERNEL + 1);

  // transaction field widths
  localparam int MODE_W = 1;
  localparam int COL_W  = 6;
  localparam int ROW_W  = 6;
  localparam int CH_W   = 2;
  localparam int PIX_W  = 8;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 48;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_SIZE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COL0     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COL1     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_COL2     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 3'd7;

  // request codes
  localparam logic [MODE_W-1:0] MODE_WRITE  = 1'b0;
  localparam logic [MODE_W-1:0] MODE_FILTER = 1'b1;

  // arithmetic
  localparam int COEF_W    = 16;
  localparam int FRAC_BITS = 12;
  localparam int OPND_W    = PIX_W + 1;
  localparam int PROD_W    = COEF_W + OPND_W;
  localparam int ACC_W     = 28;

  // saturated 8-bit value with its clamp flag
  typedef struct packed {
    logic [PIX_W-1:0] value;
    logic             clip;
  } sat_t;

endpackage

// ===== design/izp_in_if.sv =====
// ----------------------------------------------------------------------------
// izp_in_if
// Request channel: pixel writes and filter requests.
// ----------------------------------------------------------------------------
interface izp_in_if;
  logic                       valid;
  logic                       ready;
  logic [izp_pkg::MODE_W-1:0] mode;
  logic [izp_pkg::COL_W-1:0]  col;
  logic [izp_pkg::ROW_W-1:0]  row;
  logic [izp_pkg::CH_W-1:0]   channel;
  logic [izp_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, mode, col, row, channel, pixel, input ready);
  modport sink   (input valid, mode, col, row, channel, pixel, output ready);
endinterface

// ===== design/izp_out_if.sv =====
// ----------------------------------------------------------------------------
// izp_out_if
// Result channel: filtered pixel and clamp flag.
// ----------------------------------------------------------------------------
interface izp_out_if;
  logic                      valid;
  logic                      ready;
  logic [izp_pkg::PIX_W-1:0] filtered_value;
  logic                      clamped;

  modport source (output valid, filtered_value, clamped, input ready);
  modport sink   (input valid, filtered_value, clamped, output ready);
endinterface

// ===== design/image_convolution_zero_pad_core.sv =====
// Pixel write: the block stays ready for the next transaction.
// Filter request: n*n taps are issued (n*(n+1) taps and folds in separable mode),
// and the block is not ready for the next request until the result is loaded.
// Rate is set by the single multiply-accumulate unit, one tap or one partial
// fold per cycle, fed by the one read port of the frame store.
// Reset: configuration and control registers go to their defaults; the frame store is not cleared.
// ----------------------------------------------------------------------------
// image_convolution_zero_pad_core
// Stores a multi-channel 8-bit frame and returns zero-padded 2-D (or
// separable) convolution results with Q4.12 coefficients.
// ----------------------------------------------------------------------------
module image_convolution_zero_pad_core #(
  parameter int MAX_WIDTH    = izp_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT   = izp_pkg::DEF_MAX_HEIGHT,
  parameter int MAX_CHANNELS = izp_pkg::DEF_MAX_CHANNELS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [izp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [izp_pkg::CFG_DATA_W-1:0] cfg_data,
  izp_in_if.sink                         in_ch,
  izp_out_if.source                      out_ch
);
  import izp_pkg::*;

  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * MAX_CHANNELS;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_RUN   = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  localparam logic [CFG_DATA_W-1:0] COEF_COL1_RST = 48'h0000_1000_0000;
  localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-(1 << FRAC_BITS));
  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(256 << FRAC_BITS);

  // configuration registers
  logic [1:0]            kernel_size_r;
  logic                  separable_r;
  logic [CFG_DATA_W-1:0] coef_col0_r;
  logic [CFG_DATA_W-1:0] coef_col1_r;
  logic [CFG_DATA_W-1:0] coef_col2_r;
  logic [6:0]            image_width_r;
  logic [6:0]            image_height_r;
  logic [2:0]            channel_count_r;

  // sequencer
  logic [1:0]        state_r, state_nxt;
  logic [KCNT_W-1:0] i_r, i_nxt;
  logic [KCNT_W-1:0] j_r, j_nxt;
  logic              fold_r, fold_nxt;
  logic [KCNT_W-1:0] last_k;

  // request
  logic [COL_W-1:0] req_col_r;
  logic [ROW_W-1:0] req_row_r;
  logic [CH_W-1:0]  req_ch_r;

  // issue stage
  logic [KCNT_W-1:0]        kc, kr, dx, dy;
  logic                     off;
  logic signed [8:0]        sc, sr;
  logic                     tap_in;
  logic signed [COEF_W-1:0] coef;
  logic                     p_vld_r, p_vld_nxt;
  logic                     p_fold_r;
  logic                     p_in_r;
  logic signed [COEF_W-1:0] p_coef_r;

  // frame store
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [ADDR_W-1:0] wr_addr, rd_addr;
  logic [PIX_W-1:0]  rd_data_r;

  // execute stage
  sat_t                     part_sat, acc_sat;
  logic signed [OPND_W-1:0] operand;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  acc_r, part_r;
  logic                     clip_r;

  // output register
  logic             out_vld_r;
  logic [PIX_W-1:0] out_value_r;
  logic             out_clamped_r;

  // handshake and frame bounds
  logic [6:0] w_eff, h_eff;
  logic [2:0] c_eff;
  logic       in_fire, in_frame, wr_fire, req_fire, fin_load;

  // truncate toward zero, then saturate to 0..255
  function automatic sat_t sat8(input logic signed [ACC_W-1:0] a);
    sat_t s;
    if (a <= SAT_LO) begin
      s.value = '0;
      s.clip  = 1'b1;
    end else if (a < 0) begin
      s.value = '0;
      s.clip  = 1'b0;
    end else if (a >= SAT_HI) begin
      s.value = '1;
      s.clip  = 1'b1;
    end else begin
      s.value = a[FRAC_BITS+PIX_W-1:FRAC_BITS];
      s.clip  = 1'b0;
    end
    return s;
  endfunction

  // coefficient of kernel column kc, kernel row kr
  function automatic logic signed [COEF_W-1:0] coef_pick(
    input logic [KCNT_W-1:0] col_k,
    input logic [KCNT_W-1:0] row_k
  );
    logic [CFG_DATA_W-1:0] word;
    logic [COEF_W-1:0]     c;
    case (col_k)
      2'd0:    word = coef_col0_r;
      2'd1:    word = coef_col1_r;
      2'd2:    word = coef_col2_r;
      default: word = '0;
    endcase
    case (row_k)
      2'd0:    c = word[COEF_W-1:0];
      2'd1:    c = word[2*COEF_W-1:COEF_W];
      2'd2:    c = word[3*COEF_W-1:2*COEF_W];
      default: c = '0;
    endcase
    return $signed(c);
  endfunction

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kernel_size_r   <= 2'd3;
      separable_r     <= 1'b0;
      coef_col0_r     <= '0;
      coef_col1_r     <= COEF_COL1_RST;
      coef_col2_r     <= '0;
      image_width_r   <= 7'd64;
      image_height_r  <= 7'd64;
      channel_count_r <= 3'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KERNEL_SIZE:   kernel_size_r   <= cfg_data[1:0];
        REG_SEPARABLE:     separable_r     <= cfg_data[0];
        REG_COEF_COL0:     coef_col0_r     <= cfg_data;
        REG_COEF_COL1:     coef_col1_r     <= cfg_data;
        REG_COEF_COL2:     coef_col2_r     <= cfg_data;
        REG_IMAGE_WIDTH:   image_width_r   <= cfg_data[6:0];
        REG_IMAGE_HEIGHT:  image_height_r  <= cfg_data[6:0];
        REG_CHANNEL_COUNT: channel_count_r <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  // effective frame size, capped at the store geometry
  assign w_eff = (32'(image_width_r) > MAX_WIDTH) ? 7'(MAX_WIDTH) : image_width_r;
  assign h_eff = (32'(image_height_r) > MAX_HEIGHT) ? 7'(MAX_HEIGHT) : image_height_r;
  assign c_eff = (32'(channel_count_r) > MAX_CHANNELS) ? 3'(MAX_CHANNELS)
                                                         : channel_count_r;

  // input transaction decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign in_frame    = ({1'b0, in_ch.col} < w_eff) && ({1'b0, in_ch.row} < h_eff) &&
                       ({1'b0, in_ch.channel} < c_eff);
  assign wr_fire     = in_fire && in_frame && (in_ch.mode == MODE_WRITE);
  assign req_fire    = in_fire && in_frame && (in_ch.mode == MODE_FILTER);

  // latch request position
  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_col_r <= in_ch.col;
      req_row_r <= in_ch.row;
      req_ch_r  <= in_ch.channel;
    end
  end

  // tap address and coefficient for the step being issued
  assign off    = (kernel_size_r == 2'd3);
  assign last_k = KCNT_W'(kernel_size_r - 2'd1);

  always_comb begin
    dx = separable_r ? j_r : i_r;
    dy = separable_r ? i_r : j_r;
    if (fold_r) begin
      kc = '0;
      kr = i_r;
    end else begin
      kc = separable_r ? '0 : i_r;
      kr = j_r;
    end
    coef   = coef_pick(kc, kr);
    sc     = $signed({3'b000, req_col_r}) - $signed({8'b0, off}) + $signed({7'b0, dx});
    sr     = $signed({3'b000, req_row_r}) - $signed({8'b0, off}) + $signed({7'b0, dy});
    tap_in = !sc[8] && (sc < $signed({2'b00, w_eff})) &&
             !sr[8] && (sr < $signed({2'b00, h_eff}));
  end

  assign rd_addr = (ADDR_W'(sr[6:0]) * ADDR_W'(MAX_WIDTH) + ADDR_W'(sc[6:0])) *
                   ADDR_W'(MAX_CHANNELS) + ADDR_W'(req_ch_r);
  assign wr_addr = (ADDR_W'(in_ch.row) * ADDR_W'(MAX_WIDTH) + ADDR_W'(in_ch.col)) *
                   ADDR_W'(MAX_CHANNELS) + ADDR_W'(in_ch.channel);

  // frame store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_addr] <= in_ch.pixel;
    end
    rd_data_r <= mem[rd_addr];
  end

  // sequencer: one tap or partial fold issued per cycle
  always_comb begin
    state_nxt = state_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    fold_nxt  = fold_r;
    p_vld_nxt = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (req_fire) begin
          i_nxt     = '0;
          j_nxt     = '0;
          fold_nxt  = 1'b0;
          state_nxt = (kernel_size_r == 2'd0) ? ST_DRAIN : ST_RUN;
        end
      end
      ST_RUN: begin
        p_vld_nxt = 1'b1;
        if (fold_r) begin
          fold_nxt = 1'b0;
          j_nxt    = '0;
          if (i_r == last_k) state_nxt = ST_DRAIN;
          else               i_nxt     = i_r + 1'b1;
        end else if (j_r != last_k) begin
          j_nxt = j_r + 1'b1;
        end else if (separable_r) begin
          fold_nxt = 1'b1;
        end else begin
          j_nxt = '0;
          if (i_r == last_k) state_nxt = ST_DRAIN;
          else               i_nxt     = i_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (fin_load) state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      i_r     <= '0;
      j_r     <= '0;
      fold_r  <= 1'b0;
      p_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      fold_r  <= fold_nxt;
      p_vld_r <= p_vld_nxt;
    end
  end

  // issue stage payload, aligned with the read data
  always_ff @(posedge clk) begin
    if (state_r == ST_RUN) begin
      p_fold_r <= fold_r;
      p_in_r   <= tap_in;
      p_coef_r <= coef;
    end
  end

  // shared multiply-accumulate
  assign part_sat = sat8(part_r);
  assign operand  = p_fold_r ? $signed({1'b0, part_sat.value})
                             : $signed({1'b0, p_in_r ? rd_data_r : {PIX_W{1'b0}}});
  assign prod     = p_coef_r * operand;
  assign prod_ext = {{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod};

  always_ff @(posedge clk) begin
    if (req_fire) begin
      acc_r  <= '0;
      part_r <= '0;
      clip_r <= 1'b0;
    end else if (p_vld_r) begin
      if (p_fold_r) begin
        acc_r  <= acc_r + prod_ext;
        part_r <= '0;
        clip_r <= clip_r | part_sat.clip;
      end else if (separable_r) begin
        part_r <= part_r + prod_ext;
      end else begin
        acc_r <= acc_r + prod_ext;
      end
    end
  end

  // final saturation into the output register
  assign acc_sat  = sat8(acc_r);
  assign fin_load = (state_r == ST_FIN) && (!out_vld_r || out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fin_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_load) begin
      out_value_r   <= acc_sat.value;
      out_clamped_r <= clip_r | acc_sat.clip;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.filtered_value = out_value_r;
  assign out_ch.clamped        = out_clamped_r;

endmodule

// ===== design/izp_chk.sv =====
// ----------------------------------------------------------------------------
// izp_chk
// Port-level checks for the zero-padded image convolution core.
// ----------------------------------------------------------------------------
module izp_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic [izp_pkg::MODE_W-1:0] in_mode,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic [izp_pkg::PIX_W-1:0] out_value,
  input logic                      out_clamped
);
  import izp_pkg::*;

  // a result is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_value) && $stable(out_clamped))
    else $error("result payload changed while stalled");

  // the block stays ready after a pixel write
  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode == MODE_WRITE) |=> in_ready)
    else $error("not ready after a pixel write");

  // a new result only comes out of a busy filter sequence
  a_result_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !$past(in_ready))
    else $error("result appeared without a filter sequence");

endmodule

bind image_convolution_zero_pad_core izp_chk u_izp_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_mode     (in_ch.mode),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.filtered_value),
  .out_clamped (out_ch.clamped)
);
